// File: rtl/core/ocbs_pkg.sv
// ocbs_pkg: command codes, register indexes and the word types
// shared by the ordinal case bin sampler modules; no dependencies
`default_nettype none

package ocbs_pkg;

    localparam int CMD_W      = 2;
    localparam int RAND_W     = 32;
    localparam int COUNT_W    = 31;
    localparam int POOL_W     = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INDIVIDUAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE_BIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CASES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CONTROLS = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [RAND_W-1:0] random_fraction;
    } item_t;

    typedef struct packed {
        logic [POOL_W-1:0] cases_in_bin;
        logic              pool_exhausted;
        logic              status;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/ocbs_input_stage.sv
// ocbs_input_stage: input word register in front of the sampling logic
// depends on ocbs_pkg
`default_nettype none

module ocbs_input_stage
    import ocbs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [RAND_W-1:0]   random_fraction,
    input  wire logic                take,
    output logic                     stage_valid,
    output item_t                    stage_item
);

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    logic  accept;

    assign item_stall  = stage_valid_reg && !take;
    assign accept      = item_valid && !item_stall;
    assign stage_valid = stage_valid_reg;
    assign stage_item  = stage_item_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (take)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.cmd             <= cmd;
            stage_item_reg.random_fraction <= random_fraction;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ocbs_sampler.sv
// ocbs_sampler: configuration registers, run state and the pick test
// (one multiply and compare per individual); depends on ocbs_pkg
`default_nettype none

module ocbs_sampler
    import ocbs_pkg::*;
#(
    parameter int RAND_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COUNT_W-1:0]    cfg_data,
    input  wire logic                  stage_valid,
    input  wire item_t                 stage_item,
    input  wire logic                  out_free,
    output logic                       take,
    output logic                       res_load,
    output result_t                    res
);

    localparam int U_W    = (RAND_BITS < RAND_W) ? RAND_BITS : RAND_W;
    localparam int PROD_W = U_W + POOL_W;
    localparam int RHS_W  = COUNT_W + RAND_BITS;
    localparam int CMP_W  = (PROD_W > RHS_W) ? PROD_W : RHS_W;

    logic [COUNT_W-1:0] num_cases_reg, num_cases_next;
    logic [COUNT_W-1:0] num_controls_reg, num_controls_next;
    logic [COUNT_W-1:0] need_left_reg, need_left_next;
    logic [POOL_W-1:0]  pool_left_reg, pool_left_next;
    logic [POOL_W-1:0]  bin_picks_reg, bin_picks_next;
    logic [POOL_W-1:0]  bin_size_reg, bin_size_next;
    logic               overrun_reg, overrun_next;

    logic               cfg_write;
    logic               cfg_hit;
    logic               restart;
    logic [U_W-1:0]     u_eff;
    logic [PROD_W-1:0]  product;
    logic [CMP_W-1:0]   rhs;
    logic               pick;

    assign cfg_ready = !stage_valid;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_write
                       && (cfg_index == CFG_NUM_CASES || cfg_index == CFG_NUM_CONTROLS);

    assign take     = stage_valid && (stage_item.cmd != CMD_CLOSE_BIN || out_free);
    assign res_load = take && stage_item.cmd == CMD_CLOSE_BIN;
    assign restart  = cfg_hit || (take && stage_item.cmd == CMD_RESTART);

    // u * pool_left <= need_left * 2^RAND_BITS
    assign u_eff   = stage_item.random_fraction[U_W-1:0];
    assign product = PROD_W'(u_eff) * PROD_W'(pool_left_reg);
    assign rhs     = CMP_W'(need_left_reg) << RAND_BITS;
    assign pick    = (need_left_reg != '0) && (CMP_W'(product) <= rhs);

    always_comb
    begin
        res.cases_in_bin   = (num_cases_reg >= num_controls_reg)
                             ? (bin_size_reg - bin_picks_reg) : bin_picks_reg;
        res.pool_exhausted = (pool_left_reg == '0);
        res.status         = overrun_reg;
    end

    always_comb
    begin
        num_cases_next    = num_cases_reg;
        num_controls_next = num_controls_reg;
        need_left_next    = need_left_reg;
        pool_left_next    = pool_left_reg;
        bin_picks_next    = bin_picks_reg;
        bin_size_next     = bin_size_reg;
        overrun_next      = overrun_reg;

        if (cfg_write && cfg_index == CFG_NUM_CASES)
        begin
            num_cases_next = cfg_data;
        end
        if (cfg_write && cfg_index == CFG_NUM_CONTROLS)
        begin
            num_controls_next = cfg_data;
        end

        if (restart)
        begin
            need_left_next = (num_cases_next < num_controls_next)
                             ? num_cases_next : num_controls_next;
            pool_left_next = POOL_W'(num_cases_next) + POOL_W'(num_controls_next);
            bin_picks_next = '0;
            bin_size_next  = '0;
            overrun_next   = 1'b0;
        end
        else if (take)
        begin
            unique case (stage_item.cmd)
                CMD_INDIVIDUAL:
                begin
                    if (pool_left_reg == '0)
                    begin
                        overrun_next = 1'b1;
                    end
                    else
                    begin
                        if (pick)
                        begin
                            need_left_next = need_left_reg - COUNT_W'(1);
                            bin_picks_next = bin_picks_reg + POOL_W'(1);
                        end
                        pool_left_next = pool_left_reg - POOL_W'(1);
                        bin_size_next  = bin_size_reg + POOL_W'(1);
                    end
                end
                CMD_CLOSE_BIN:
                begin
                    bin_picks_next = '0;
                    bin_size_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cases_reg    <= '0;
            num_controls_reg <= '0;
            need_left_reg    <= '0;
            pool_left_reg    <= '0;
            bin_picks_reg    <= '0;
            bin_size_reg     <= '0;
            overrun_reg      <= 1'b0;
        end
        else
        begin
            num_cases_reg    <= num_cases_next;
            num_controls_reg <= num_controls_next;
            need_left_reg    <= need_left_next;
            pool_left_reg    <= pool_left_next;
            bin_picks_reg    <= bin_picks_next;
            bin_size_reg     <= bin_size_next;
            overrun_reg      <= overrun_next;
        end
    end

    // sample still needed can never exceed what is left of the pool
    a_need_within_pool: assert property (@(posedge clk) disable iff (!rst_n)
        POOL_W'(need_left_reg) <= pool_left_reg)
        else $error("need_left above pool_left");

    a_picks_within_bin: assert property (@(posedge clk) disable iff (!rst_n)
        bin_picks_reg <= bin_size_reg)
        else $error("bin picks above bin size");

    a_overrun_on_empty_pool: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overrun_reg) |-> $past(pool_left_reg) == '0)
        else $error("overrun set with individuals left");

    a_close_waits_for_output: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free && stage_valid)
        else $error("bin closed without room for the result");

endmodule

`default_nettype wire

// File: rtl/core/ocbs_output_stage.sv
// ocbs_output_stage: result word register towards the downstream side
// depends on ocbs_pkg
`default_nettype none

module ocbs_output_stage
    import ocbs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_load,
    input  wire result_t            res,
    output logic                    out_free,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [POOL_W-1:0]       cases_in_bin,
    output logic                    pool_exhausted,
    output logic                    status
);

    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;

    assign out_free       = !result_valid_reg || !result_stall;
    assign result_valid   = result_valid_reg;
    assign cases_in_bin   = result_reg.cases_in_bin;
    assign pool_exhausted = result_reg.pool_exhausted;
    assign status         = result_reg.status;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (res_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg <= res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ordinal_case_bin_sampler_core.sv
// ordinal_case_bin_sampler_core: an item is held in the input register and a result in
// the output register; result valid the cycle after the item leaves the input register
// throughput one item per cycle; the pick multiply and compare feeds need_left and
// pool_left back combinationally; a close-bin word waits while the result stalls
// asynchronous active-low reset clears configuration and run state to zero
// built from ocbs_input_stage, ocbs_sampler and ocbs_output_stage; uses ocbs_pkg
`default_nettype none

module ordinal_case_bin_sampler_core
    import ocbs_pkg::*;
#(
    parameter int RAND_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COUNT_W-1:0]    cfg_data,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic [CMD_W-1:0]      cmd,
    input  wire logic [RAND_W-1:0]     random_fraction,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic [POOL_W-1:0]          cases_in_bin,
    output logic                       pool_exhausted,
    output logic                       status
);

    logic    take;
    logic    stage_valid;
    item_t   stage_item;
    logic    out_free;
    logic    res_load;
    result_t res;

    ocbs_input_stage u_input_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .cmd             (cmd),
        .random_fraction (random_fraction),
        .take            (take),
        .stage_valid     (stage_valid),
        .stage_item      (stage_item)
    );

    ocbs_sampler #(
        .RAND_BITS (RAND_BITS)
    ) u_sampler (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .out_free    (out_free),
        .take        (take),
        .res_load    (res_load),
        .res         (res)
    );

    ocbs_output_stage u_output_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_load       (res_load),
        .res            (res),
        .out_free       (out_free),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .cases_in_bin   (cases_in_bin),
        .pool_exhausted (pool_exhausted),
        .status         (status)
    );

endmodule

`default_nettype wire
